FILE: sv/word_stream_repacker_unit_macros.svh
// ----------------------------------------------------------------------------
// Word stream repacker assertion macros
// Shared property shorthands; the using module provides clock and reset.
// ----------------------------------------------------------------------------
`ifndef WORD_STREAM_REPACKER_UNIT_MACROS_SVH
`define WORD_STREAM_REPACKER_UNIT_MACROS_SVH

// Same-cycle implication, ignored during reset
`define WSR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored during reset
`define WSR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/wsr_pkg.sv
// ----------------------------------------------------------------------------
// Word stream repacker package
// Payload types, widths and lane packing helpers shared by all modules.
// ----------------------------------------------------------------------------
package wsr_pkg;

   localparam int MAX_LANES       = 16;
   localparam int WORD_W          = 32;
   localparam int W_IDX_W         = $clog2(MAX_LANES);
   localparam int COUNT_W         = 5;
   localparam int LEN_W           = 7;
   localparam int LANES_DEF       = 16;
   localparam int QUEUE_DEPTH_DEF = 2;

   typedef logic [MAX_LANES-1:0][WORD_W-1:0] words_type;

   typedef struct packed {
      logic [63:0]        in_lanes_0_1;
      logic [63:0]        in_lanes_2_3;
      logic [63:0]        in_lanes_4_5;
      logic [63:0]        in_lanes_6_7;
      logic [63:0]        in_lanes_8_9;
      logic [63:0]        in_lanes_10_11;
      logic [63:0]        in_lanes_12_13;
      logic [63:0]        in_lanes_14_15;
      logic [COUNT_W-1:0] valid_count;
      logic               packet_end;
   } req_type;

   typedef struct packed {
      logic [63:0]      out_lanes_0_1;
      logic [63:0]      out_lanes_2_3;
      logic [63:0]      out_lanes_4_5;
      logic [63:0]      out_lanes_6_7;
      logic [63:0]      out_lanes_8_9;
      logic [63:0]      out_lanes_10_11;
      logic [63:0]      out_lanes_12_13;
      logic [63:0]      out_lanes_14_15;
      logic [LEN_W-1:0] byte_length;
      logic             packet_last;
   } rsp_type;

   // Classified beat as it waits between front and back
   typedef struct packed {
      words_type          words;
      logic [COUNT_W-1:0] count;
      logic               last;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } qhead_type;

   function automatic words_type unpack_words(req_type req);
      words_type w;
      w[0]  = req.in_lanes_0_1[31:0];
      w[1]  = req.in_lanes_0_1[63:32];
      w[2]  = req.in_lanes_2_3[31:0];
      w[3]  = req.in_lanes_2_3[63:32];
      w[4]  = req.in_lanes_4_5[31:0];
      w[5]  = req.in_lanes_4_5[63:32];
      w[6]  = req.in_lanes_6_7[31:0];
      w[7]  = req.in_lanes_6_7[63:32];
      w[8]  = req.in_lanes_8_9[31:0];
      w[9]  = req.in_lanes_8_9[63:32];
      w[10] = req.in_lanes_10_11[31:0];
      w[11] = req.in_lanes_10_11[63:32];
      w[12] = req.in_lanes_12_13[31:0];
      w[13] = req.in_lanes_12_13[63:32];
      w[14] = req.in_lanes_14_15[31:0];
      w[15] = req.in_lanes_14_15[63:32];
      return w;
   endfunction

   function automatic rsp_type pack_rsp(words_type w, logic [LEN_W-1:0] len, logic last);
      rsp_type r;
      r.out_lanes_0_1   = {w[1], w[0]};
      r.out_lanes_2_3   = {w[3], w[2]};
      r.out_lanes_4_5   = {w[5], w[4]};
      r.out_lanes_6_7   = {w[7], w[6]};
      r.out_lanes_8_9   = {w[9], w[8]};
      r.out_lanes_10_11 = {w[11], w[10]};
      r.out_lanes_12_13 = {w[13], w[12]};
      r.out_lanes_14_15 = {w[15], w[14]};
      r.byte_length     = len;
      r.packet_last     = last;
      return r;
   endfunction

endpackage

FILE: sv/wsr_front.sv
// ----------------------------------------------------------------------------
// Word stream repacker front end
// Accepts input beats, clamps the word count and queues them for the back end.
// ----------------------------------------------------------------------------
`include "word_stream_repacker_unit_macros.svh"

module wsr_front #(
   parameter int LANES       = wsr_pkg::LANES_DEF,
   parameter int QUEUE_DEPTH = wsr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  wsr_pkg::req_type   req_data,
   input  logic               pop,
   output wsr_pkg::qhead_type head
);

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [wsr_pkg::COUNT_W-1:0] LANES_CNT = wsr_pkg::COUNT_W'(LANES);
   localparam logic [PTR_W-1:0]  LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);

   wsr_pkg::item_type queue_ff [QUEUE_DEPTH];
   wsr_pkg::item_type item_in;

   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              push;

   assign req_stall = (fill_ff == FULL_FILL);
   assign push      = req_valid && !req_stall;

   // Clamp oversized counts to the beat width
   always_comb begin
      item_in.words = wsr_pkg::unpack_words(req_data);
      item_in.count = (req_data.valid_count > LANES_CNT) ? LANES_CNT : req_data.valid_count;
      item_in.last  = req_data.packet_end;
   end

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (push) begin
         tail_in = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[tail_ff] <= item_in;
      end
   end

   assign head.valid = (fill_ff != '0);
   assign head.item  = queue_ff[head_ff];

   `WSR_ASSERT_NOW(a_pop_nonempty, pop, fill_ff != '0, "pop from empty queue")
   `WSR_ASSERT_NEXT(a_fill_grows, push && !pop, fill_ff == FILL_W'($past(fill_ff) + 1'b1), "queue fill did not grow on transfer")

endmodule

FILE: sv/wsr_back.sv
// ----------------------------------------------------------------------------
// Word stream repacker back end
// Appends queued words to the staging vector and emits full and flush beats.
// ----------------------------------------------------------------------------
`include "word_stream_repacker_unit_macros.svh"

module wsr_back #(
   parameter int LANES = wsr_pkg::LANES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  wsr_pkg::qhead_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output wsr_pkg::rsp_type   rsp_data
);

   localparam int CNT_W = $clog2(LANES);
   localparam int TOT_W = $clog2(2 * LANES);
   localparam logic [TOT_W-1:0]           LANES_TOT = TOT_W'(LANES);
   localparam logic [wsr_pkg::LEN_W-1:0]  FULL_LEN  = wsr_pkg::LEN_W'(4 * LANES);

   logic [wsr_pkg::WORD_W-1:0] staged_ff [LANES];
   logic [wsr_pkg::WORD_W-1:0] staged_in [LANES];
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       flush_pending_ff, flush_pending_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   wsr_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   logic [wsr_pkg::W_IDX_W-1:0] lo_idx [LANES];
   logic [wsr_pkg::W_IDX_W-1:0] hi_idx [LANES];
   wsr_pkg::words_type          w;
   wsr_pkg::words_type          full_words;
   wsr_pkg::words_type          flush_words;
   logic [TOT_W-1:0]            total;
   logic [TOT_W-1:0]            left;
   logic                        full;
   logic                        advance;

   assign w       = head.item.words;
   assign total   = TOT_W'(count_ff) + TOT_W'(head.item.count);
   assign full    = (total >= LANES_TOT);
   assign left    = total - LANES_TOT;
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && !flush_pending_ff && head.valid;

   // Input word feeding each lane: shifted past the staged words, or past a full beat
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         lo_idx[i] = wsr_pkg::W_IDX_W'(i - int'(count_ff));
         hi_idx[i] = wsr_pkg::W_IDX_W'(i + LANES - int'(count_ff));
      end
   end

   always_comb begin
      full_words  = '0;
      flush_words = '0;
      for (int i = 0; i < LANES; i++) begin
         full_words[i]  = (CNT_W'(i) < count_ff) ? staged_ff[i] : w[lo_idx[i]];
         flush_words[i] = (CNT_W'(i) < count_ff) ? staged_ff[i] : '0;
         if (full) begin
            staged_in[i] = (TOT_W'(i) < left) ? w[hi_idx[i]] : staged_ff[i];
         end else begin
            staged_in[i] = ((CNT_W'(i) >= count_ff) && (TOT_W'(i) < total)) ?
                           w[lo_idx[i]] : staged_ff[i];
         end
      end
   end

   always_comb begin
      count_in         = count_ff;
      flush_pending_in = flush_pending_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_data_in      = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b0;
         if (flush_pending_ff) begin
            // Drain the staged remainder as the closing beat
            rsp_valid_in     = 1'b1;
            rsp_data_in      = wsr_pkg::pack_rsp(flush_words,
                                  wsr_pkg::LEN_W'({count_ff, 2'b00}), 1'b1);
            count_in         = '0;
            flush_pending_in = 1'b0;
         end else if (head.valid) begin
            count_in         = full ? CNT_W'(left) : CNT_W'(total);
            flush_pending_in = head.item.last;
            if (full) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = wsr_pkg::pack_rsp(full_words, FULL_LEN, 1'b0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff         <= '0;
         flush_pending_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         count_ff         <= count_in;
         flush_pending_ff <= flush_pending_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (pop) begin
         for (int i = 0; i < LANES; i++) begin
            staged_ff[i] <= staged_in[i];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `WSR_ASSERT_NEXT(a_flush_emits, advance && flush_pending_ff, rsp_valid_ff && rsp_data_ff.packet_last && (count_ff == '0), "flush beat not issued")
   `WSR_ASSERT_NOW(a_full_len, rsp_valid_ff && !rsp_data_ff.packet_last, rsp_data_ff.byte_length == FULL_LEN, "full beat with short length")
   `WSR_ASSERT_NOW(a_flush_len, rsp_valid_ff && rsp_data_ff.packet_last, rsp_data_ff.byte_length < FULL_LEN, "flush beat with full length")

endmodule

FILE: sv/word_stream_repacker_unit.sv
// ----------------------------------------------------------------------------
// Word stream repacker
// Packs variable-count word beats into full beats, flushing at packet end.
// ----------------------------------------------------------------------------
//   channel   valid      stall      payload
//   input     req_valid  req_stall  req_data  (wsr_pkg::req_type)
//   output    rsp_valid  rsp_stall  rsp_data  (wsr_pkg::rsp_type)
//
// One input beat is taken per cycle while req_stall is low; a beat with packet_end
// adds a separate flush beat on the output, read from the staging register.
// An input beat is registered in the queue, and its full beat in the output register.
// Reset clears the queue, the staged count and the output valid; no sweep.
// Either side may stall; the queue absorbs up to QUEUE_DEPTH beats.
// ----------------------------------------------------------------------------
module word_stream_repacker_unit #(
   parameter int LANES       = wsr_pkg::LANES_DEF,
   parameter int QUEUE_DEPTH = wsr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wsr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wsr_pkg::rsp_type rsp_data
);

   wsr_pkg::qhead_type head;
   logic               pop;

   wsr_front #(
      .LANES       (LANES),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .pop       (pop),
      .head      (head)
   );

   wsr_back #(
      .LANES (LANES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Word stream repacker testbench
// Drives word beats with random gaps and output stalls, predicts the packed
// full beats and packet-end flush beats, and checks every output transfer.
// ----------------------------------------------------------------------------
module testbench;

   localparam int LANE_COUNT     = wsr_pkg::LANES_DEF;
   localparam int HOLD_CYCLES    = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int FIELD_COUNT    = 10;

   typedef logic [15:0][31:0] word_vec_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   wsr_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   wsr_pkg::rsp_type rsp_data;

   // predictor state
   word_vec_type     staging     = '0;
   int unsigned      staged_fill = 0;
   wsr_pkg::rsp_type expected_beats [$];

   int unsigned error_count        = 0;
   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   bit          hold_toggle        = 1'b0;
   bit          hold_seen          = 1'b0;
   int unsigned hold_left          = 0;
   int unsigned quiet_cycles       = 0;

   string field_name [FIELD_COUNT] = '{
      "out_lanes_0_1", "out_lanes_2_3", "out_lanes_4_5", "out_lanes_6_7",
      "out_lanes_8_9", "out_lanes_10_11", "out_lanes_12_13", "out_lanes_14_15",
      "byte_length", "packet_last"
   };

   word_stream_repacker_unit #(
      .LANES (LANE_COUNT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Packed beat construction and prediction
   // -------------------------------------------------------------------------
   function automatic wsr_pkg::rsp_type build_beat(word_vec_type words, int unsigned n,
                                                   logic last);
      wsr_pkg::rsp_type r;
      word_vec_type     masked;
      for (int i = 0; i < 16; i++)
         masked[i] = (i < n) ? words[i] : 32'd0;
      {r.out_lanes_14_15, r.out_lanes_12_13, r.out_lanes_10_11, r.out_lanes_8_9,
       r.out_lanes_6_7, r.out_lanes_4_5, r.out_lanes_2_3, r.out_lanes_0_1} = masked;
      r.byte_length = 7'(4 * n);
      r.packet_last = last;
      return r;
   endfunction

   function automatic wsr_pkg::req_type make_beat(word_vec_type words, logic [4:0] count,
                                                  logic last);
      wsr_pkg::req_type b;
      {b.in_lanes_14_15, b.in_lanes_12_13, b.in_lanes_10_11, b.in_lanes_8_9,
       b.in_lanes_6_7, b.in_lanes_4_5, b.in_lanes_2_3, b.in_lanes_0_1} = words;
      b.valid_count = count;
      b.packet_end  = last;
      return b;
   endfunction

   function automatic word_vec_type random_words();
      word_vec_type w;
      int unsigned  pick;
      for (int i = 0; i < 16; i++) begin
         pick = $urandom_range(19);
         w[i] = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : 32'($urandom);
      end
      return w;
   endfunction

   function automatic logic [FIELD_COUNT-1:0][63:0] split_fields(wsr_pkg::rsp_type r);
      logic [FIELD_COUNT-1:0][63:0] f;
      f[0] = r.out_lanes_0_1;
      f[1] = r.out_lanes_2_3;
      f[2] = r.out_lanes_4_5;
      f[3] = r.out_lanes_6_7;
      f[4] = r.out_lanes_8_9;
      f[5] = r.out_lanes_10_11;
      f[6] = r.out_lanes_12_13;
      f[7] = r.out_lanes_14_15;
      f[8] = 64'(r.byte_length);
      f[9] = 64'(r.packet_last);
      return f;
   endfunction

   task automatic predict_packing(input wsr_pkg::req_type beat);
      word_vec_type words;
      word_vec_type full;
      int unsigned  take;
      int unsigned  fill;
      int unsigned  total;
      int unsigned  left;
      {words} = {beat.in_lanes_14_15, beat.in_lanes_12_13, beat.in_lanes_10_11,
                 beat.in_lanes_8_9, beat.in_lanes_6_7, beat.in_lanes_4_5,
                 beat.in_lanes_2_3, beat.in_lanes_0_1};
      // clamp oversized counts; words past the lane count never enter
      take  = (beat.valid_count > LANE_COUNT) ? LANE_COUNT : beat.valid_count;
      fill  = (staged_fill >= LANE_COUNT) ? LANE_COUNT - 1 : staged_fill;
      total = fill + take;
      if (total >= LANE_COUNT) begin
         left = total - LANE_COUNT;
         for (int i = 0; i < LANE_COUNT; i++)
            full[i] = (i < fill) ? staging[i] : words[(i - fill) % 16];
         for (int i = 0; i < left; i++)
            staging[i] = words[(i + LANE_COUNT - fill) % 16];
         expected_beats.push_back(build_beat(full, LANE_COUNT, 1'b0));
         fill = left;
      end else begin
         for (int i = 0; i < take; i++)
            staging[(fill + i) % 16] = words[i];
         fill = total;
      end
      // flush always follows at packet end, even with nothing left staged
      if (beat.packet_end) begin
         expected_beats.push_back(build_beat(staging, fill, 1'b1));
         fill = 0;
      end
      staged_fill = fill % 16;
   endtask

   // -------------------------------------------------------------------------
   // Sender
   // -------------------------------------------------------------------------
   task automatic send_beat(input wsr_pkg::req_type beat);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      predict_packing(beat);
   endtask

   task automatic send_random_packets(input int unsigned beat_total);
      int unsigned sent;
      int unsigned pkt_len;
      int unsigned pick;
      logic [4:0]  count;
      sent = 0;
      while (sent < beat_total) begin
         pkt_len = $urandom_range(8, 1);
         for (int b = 0; b < pkt_len; b++) begin
            pick = $urandom_range(99);
            if (pick < 8)
               count = 5'($urandom_range(31, 17));
            else if (pick < 20)
               count = 5'd16;
            else
               count = 5'($urandom_range(16, 0));
            send_beat(make_beat(random_words(), count, b == pkt_len - 1));
            sent++;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Receiver, checker and watchdog
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin : check_beats
      wsr_pkg::rsp_type             want;
      logic [FIELD_COUNT-1:0][63:0] want_f;
      logic [FIELD_COUNT-1:0][63:0] got_f;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected output transfer: expected none, got %h",
                     $time, rsp_data);
            error_count++;
         end else begin
            want   = expected_beats.pop_front();
            want_f = split_fields(want);
            got_f  = split_fields(rsp_data);
            for (int i = 0; i < FIELD_COUNT; i++) begin
               if (got_f[i] !== want_f[i]) begin
                  $display("%0t: %s mismatch: expected %h, got %h",
                           $time, field_name[i], want_f[i], got_f[i]);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog: no transfer for %0d cycles", $time, quiet_cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   task automatic test_directed_cases();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_beat(make_beat('0, 5'd0, 1'b0));                    // nothing valid
      send_beat(make_beat(random_words(), 5'd0, 1'b1));        // empty packet end
      send_beat(make_beat('1, 5'd16, 1'b0));
      send_beat(make_beat(random_words(), 5'd16, 1'b1));       // full beat, empty flush
      send_beat(make_beat(random_words(), 5'd5, 1'b0));
      send_beat(make_beat(random_words(), 5'd7, 1'b0));
      send_beat(make_beat(random_words(), 5'd9, 1'b0));        // wrap with leftovers
      send_beat(make_beat(random_words(), 5'd3, 1'b1));
      send_beat(make_beat({16{32'hAAAA_AAAA}}, 5'd31, 1'b0));  // oversized count
      send_beat(make_beat({16{32'h5555_5555}}, 5'd17, 1'b0));
      send_beat(make_beat(random_words(), 5'd15, 1'b0));       // deepest fill
      send_beat(make_beat(random_words(), 5'd16, 1'b1));       // full beat plus 60-byte flush
      send_beat(make_beat(random_words(), 5'd1, 1'b0));
      send_beat(make_beat(random_words(), 5'd15, 1'b1));
      send_beat(make_beat(random_words(), 5'd15, 1'b0));
      send_beat(make_beat(random_words(), 5'd1, 1'b0));
      send_beat(make_beat(random_words(), 5'd20, 1'b1));
      send_beat(make_beat('1, 5'd8, 1'b1));
      send_beat(make_beat('0, 5'd16, 1'b0));
      send_beat(make_beat(random_words(), 5'd11, 1'b1));
   endtask

   task automatic test_streaming();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_random_packets(300);
   endtask

   task automatic test_sender_gaps();
      sender_idle_pct    = 79;
      receiver_stall_pct = 0;
      send_random_packets(250);
   endtask

   task automatic test_receiver_stalls();
      sender_idle_pct    = 0;
      receiver_stall_pct = 79;
      send_random_packets(250);
   endtask

   task automatic test_mixed_idling();
      sender_idle_pct    = 11;
      receiver_stall_pct = 11;
      send_random_packets(250);
   endtask

   task automatic test_output_backpressure();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      // long receiver hold while beats keep coming, so the input stalls
      hold_toggle = ~hold_toggle;
      send_random_packets(100);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_streaming();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_idling();
      test_output_backpressure();
      req_valid <= 1'b0;
      receiver_stall_pct = 0;
      while (expected_beats.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_beats.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+sv
sv/wsr_pkg.sv
sv/wsr_front.sv
sv/wsr_back.sv
sv/word_stream_repacker_unit.sv
dv/testbench.sv
